// ----- src/hdpu_pkg.sv -----
// Package for the H-bridge duty and polarity update block.
// Types, fixed field widths, register indexes and controller codes.
// No dependencies.
package hdpu_pkg;

  localparam int SP_W    = 12;
  localparam int CMP_W   = 14;
  localparam int FREQ_W  = 10;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 14;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W  = SP_W + CMP_W;   // setpoint * period
  localparam int THR_W   = 13;             // holds 8000
  localparam int DUTY_W  = 15;             // 4095*16383/2500 < 2**15

  // product/2500 == (product>>2)/625, done as a multiply by ceil(2**34/625)
  // and a 34-bit right shift; exact for any 24-bit quarter product
  localparam int QIN_W    = PROD_W - 2;
  localparam int RECIP_W  = 25;
  localparam int RECIP_SH = 34;
  localparam int RPROD_W  = QIN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DUTY_RECIP = RECIP_W'(27487791);

  localparam logic [SP_W-1:0]  SP_FULL_SCALE   = SP_W'(2500);
  localparam logic [THR_W-1:0] TICKS_HALF_SCALE = THR_W'(8000);

  localparam logic [CFG_IDX_W-1:0] REG_AC_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AC_FREQ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PER   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY  = 2'd3;

  localparam logic [FREQ_W-1:0] AC_FREQ_RST  = FREQ_W'(100);
  localparam logic [CMP_W-1:0]  PWM_PER_RST  = CMP_W'(4500);
  localparam logic [CMP_W-1:0]  MAX_DUTY_RST = CMP_W'(4185);

  typedef struct packed {
    logic            fault_in;
    logic            active;
    logic [SP_W-1:0] setpoint;
  } in_t;

  typedef struct packed {
    logic [CMP_W-1:0] ch1_compare;
    logic [CMP_W-1:0] ch2_compare;
    logic             outputs_enabled;
    logic             fault_trip;
    logic             polarity;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_hold;
  } ctrl_sts_t;

endpackage

// ----- src/hdpu_div.sv -----
// Restoring shift-subtract divider, one quotient bit per cycle.
// Generic widths; no package dependencies.
module hdpu_div #(
  parameter int N = 26,
  parameter int M = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  output logic         busy,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  qr;
  logic [M-1:0]  rem;
  logic [M-1:0]  dsr;
  logic [CW-1:0] count;
  logic [M:0]    rem_shift;
  logic          take;

  assign rem_shift = {rem, qr[N-1]};
  assign take      = rem_shift >= {1'b0, dsr};
  assign quotient  = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CW'(N);
    end else if (busy) begin
      count <= count - CW'(1);
      if (count == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr  <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      qr <= {qr[N-2:0], take};
      if (take) begin
        rem <= M'(rem_shift - {1'b0, dsr});
      end else begin
        rem <= rem_shift[M-1:0];
      end
    end
  end

endmodule

// ----- src/hdpu_ctrl.sv -----
// Sequencer for one tick: capture, multiply, divide, commit.
// Depends on hdpu_pkg.
module hdpu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hdpu_pkg::ctrl_sts_t sts,
  output hdpu_pkg::ctrl_cmd_t cmd
);
  import hdpu_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MUL;
      ST_MUL:    state_next = ST_START;
      ST_START:  state_next = ST_DIV;
      ST_DIV:    if (!sts.div_busy) state_next = ST_COMMIT;
      ST_COMMIT: if (!sts.out_hold) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_MUL:    cmd.mul = 1'b1;
      ST_START:  cmd.div_start = 1'b1;
      ST_DIV:    cmd = '0;
      ST_COMMIT: cmd.commit = !sts.out_hold;
      default:   cmd = '0;
    endcase
  end

endmodule

// ----- src/hdpu_datapath.sv -----
// Datapath: config registers, product, reciprocal divide by 2500, threshold
// divider, AC counter, output register. Depends on hdpu_pkg and hdpu_div.
module hdpu_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [hdpu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hdpu_pkg::CFG_W-1:0] cfg_data,
  input  hdpu_pkg::in_t              in_data,
  output hdpu_pkg::out_t             out_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  input  hdpu_pkg::ctrl_cmd_t        cmd,
  output hdpu_pkg::ctrl_sts_t        sts
);
  import hdpu_pkg::*;

  logic              ac_mode;
  logic [FREQ_W-1:0] ac_freq;
  logic [CMP_W-1:0]  pwm_per;
  logic [CMP_W-1:0]  max_duty;

  in_t               item;
  logic [PROD_W-1:0] product;
  logic [CNT_W-1:0]  half_cnt;
  logic              side;

  logic [FREQ_W-1:0]  freq_eff;
  logic [RPROD_W-1:0] recip_prod;
  logic [DUTY_W-1:0]  duty_quot;
  logic [THR_W-1:0]   thr_quot;
  logic               thr_busy;

  logic [DUTY_W-1:0] duty_raw;
  logic [CMP_W-1:0]  duty;
  logic              act;
  logic [CNT_W-1:0]  cnt_inc;
  logic              wrap;
  logic [CNT_W-1:0]  half_cnt_next;
  logic              side_next;
  out_t              out_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ac_mode  <= 1'b0;
      ac_freq  <= AC_FREQ_RST;
      pwm_per  <= PWM_PER_RST;
      max_duty <= MAX_DUTY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AC_MODE:  ac_mode  <= cfg_data[0];
        REG_AC_FREQ:  ac_freq  <= cfg_data[FREQ_W-1:0];
        REG_PWM_PER:  pwm_per  <= cfg_data;
        REG_MAX_DUTY: max_duty <= cfg_data;
        default:      ac_mode  <= ac_mode;
      endcase
    end
  end

  // quarter product times the reciprocal of 625
  assign recip_prod = RPROD_W'(product[PROD_W-1:2]) * RPROD_W'(DUTY_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item <= in_data;
    end
    if (cmd.mul) begin
      product <= PROD_W'(item.setpoint) * PROD_W'(pwm_per);
    end
    if (cmd.div_start) begin
      duty_quot <= recip_prod[RECIP_SH +: DUTY_W];
    end
  end

  // zero frequency runs as 1 Hz
  assign freq_eff = (ac_freq == '0) ? FREQ_W'(1) : ac_freq;

  hdpu_div #(.N(THR_W), .M(FREQ_W)) u_div_thr (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (TICKS_HALF_SCALE),
    .divisor  (freq_eff),
    .busy     (thr_busy),
    .quotient (thr_quot)
  );

  assign sts.div_busy = thr_busy;
  assign sts.out_hold = out_valid & out_stall;

  // clamp and polarity steering
  always_comb begin
    duty_raw      = duty_quot;
    duty          = (duty_raw > {1'b0, max_duty}) ? max_duty : duty_raw[CMP_W-1:0];
    act           = item.active & ~item.fault_in;
    cnt_inc       = half_cnt + CNT_W'(1);
    wrap          = cnt_inc >= CNT_W'(thr_quot);
    half_cnt_next = half_cnt;
    side_next     = side;
    out_next      = '0;
    out_next.fault_trip = item.fault_in;
    if (act) begin
      out_next.outputs_enabled = 1'b1;
      if (ac_mode) begin
        half_cnt_next = wrap ? '0 : cnt_inc;
        side_next     = wrap ? ~side : side;
        out_next.polarity = side_next;
        if (side_next) begin
          out_next.ch2_compare = duty;
        end else begin
          out_next.ch1_compare = duty;
        end
      end else begin
        out_next.ch1_compare = duty;
      end
    end else if (ac_mode) begin
      out_next.polarity = side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_cnt  <= '0;
      side      <= 1'b0;
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      half_cnt  <= half_cnt_next;
      side      <= side_next;
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= out_next;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("commit over a held result");

  a_side_only_on_commit: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(side) && $stable(half_cnt))
    else $error("AC state moved without a commit");

  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.outputs_enabled |->
      out_data.ch1_compare == '0 && out_data.ch2_compare == '0)
    else $error("nonzero compare with bridge off");

  a_trip_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fault_trip |-> !out_data.outputs_enabled)
    else $error("bridge enabled during fault");

endmodule

// ----- src/hbridge_duty_polarity_update.sv -----
// Top level of the H-bridge duty and polarity update block.
// Depends on hdpu_pkg, hdpu_ctrl, hdpu_datapath (and hdpu_div below it).
//
// Usage:
//   One input transfer per PWM period carries fault_in, active and setpoint.
//   Each one yields exactly one output transfer with both leg compare values,
//   the bridge enable, the fault trip flag and the AC polarity.
//   Both channels use valid/stall; a transfer happens on a rising edge with
//   valid high and stall low.
//   Config: cfg_we/cfg_index/cfg_data write ac_mode_enable (0), ac_frequency (1),
//   pwm_period (2), max_duty (3); write only while no tick is in flight.
// Sequence:
//   An accepted tick is multiplied, then divided by 2500 through a
//   reciprocal multiply, while 8000/frequency runs through a
//   13-step shift-subtract divider. The result lands in the output register
//   once that divider is done; the next tick can be taken in the cycle after
//   that commit, so one tick is worked on at a time. While the receiver stalls,
//   the result holds and the next tick is still worked on; it waits at commit
//   until the held result is taken.
// Reset (rst, synchronous): registers to defaults, AC counter and side clear.
module hbridge_duty_polarity_update (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hdpu_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hdpu_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [hdpu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hdpu_pkg::CFG_W-1:0]    cfg_data
);
  import hdpu_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: one tick in flight at a time
  hdpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, AC state and the output register
  hdpu_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- tb/hbridge_duty_polarity_update_test.sv -----
// Self-checking testbench for hbridge_duty_polarity_update.
// Depends on hdpu_pkg and the block's RTL. A tracker class predicts each update
// from accepted ticks; tasks drive ticks and register writes with random idling.
import hdpu_pkg::*;

class duty_polarity_tracker;
  localparam int MAX_REPORTS = 10;

  // Shadow registers and AC state, all at their reset values
  logic              ac_mode  = 1'b0;
  logic [FREQ_W-1:0] ac_freq  = AC_FREQ_RST;
  logic [CMP_W-1:0]  pwm_per  = PWM_PER_RST;
  logic [CMP_W-1:0]  duty_cap = MAX_DUTY_RST;
  logic [CNT_W-1:0]  half_cnt = '0;
  logic              side     = 1'b0;

  out_t pending_updates[$];
  int   mismatches = 0;
  int   updates = 0;
  int   ticks = 0;
  int   trips = 0;
  int   flips = 0;
  int   clamps = 0;

  // Register write: only the low bits of each register's width are kept
  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_AC_MODE:  ac_mode  = data[0];
      REG_AC_FREQ:  ac_freq  = data[FREQ_W-1:0];
      REG_PWM_PER:  pwm_per  = data;
      REG_MAX_DUTY: duty_cap = data;
      default: ;
    endcase
  endfunction

  function void note_tick(in_t t);
    logic [PROD_W-1:0] prod;
    logic [DUTY_W-1:0] duty;
    logic [FREQ_W-1:0] freq;
    logic [THR_W-1:0]  thr;
    out_t              upd;
    upd = '0;
    ticks++;
    upd.fault_trip = t.fault_in;
    if (t.fault_in) trips++;
    // fault overrides the drive request
    if (t.active && !t.fault_in) begin
      prod = PROD_W'(t.setpoint) * PROD_W'(pwm_per);
      duty = DUTY_W'(prod / PROD_W'(SP_FULL_SCALE));
      if (duty > DUTY_W'(duty_cap)) begin
        duty = DUTY_W'(duty_cap);
        clamps++;
      end
      upd.outputs_enabled = 1'b1;
      if (ac_mode) begin
        // zero frequency behaves as 1 Hz
        freq = (ac_freq == '0) ? FREQ_W'(1) : ac_freq;
        thr = TICKS_HALF_SCALE / THR_W'(freq);
        half_cnt = half_cnt + 1'b1;
        // >= also catches a count left above a newly shortened threshold
        if (half_cnt >= CNT_W'(thr)) begin
          half_cnt = '0;
          side = ~side;
          flips++;
        end
        if (side) upd.ch2_compare = duty[CMP_W-1:0];
        else upd.ch1_compare = duty[CMP_W-1:0];
        upd.polarity = side;
      end else begin
        upd.ch1_compare = duty[CMP_W-1:0];
      end
    end else if (ac_mode) begin
      upd.polarity = side;
    end
    pending_updates.push_back(upd);
  endfunction

  function void check_update(out_t got);
    out_t want;
    bit   bad;
    updates++;
    if (pending_updates.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected update: ch1=%0d ch2=%0d en=%0b trip=%0b pol=%0b",
                 got.ch1_compare, got.ch2_compare, got.outputs_enabled,
                 got.fault_trip, got.polarity);
      return;
    end
    want = pending_updates.pop_front();
    bad = (got.ch1_compare !== want.ch1_compare) ||
          (got.ch2_compare !== want.ch2_compare) ||
          (got.outputs_enabled !== want.outputs_enabled) ||
          (got.fault_trip !== want.fault_trip) ||
          (got.polarity !== want.polarity);
    if (bad) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("update %0d expected: ch1=%0d ch2=%0d en=%0b trip=%0b pol=%0b",
                 updates, want.ch1_compare, want.ch2_compare,
                 want.outputs_enabled, want.fault_trip, want.polarity);
        $display("update %0d actual:   ch1=%0d ch2=%0d en=%0b trip=%0b pol=%0b",
                 updates, got.ch1_compare, got.ch2_compare,
                 got.outputs_enabled, got.fault_trip, got.polarity);
      end
    end
  endfunction
endclass

module hbridge_duty_polarity_update_test;
  localparam int CLK_HALF          = 6;
  localparam int RESET_CYCLES      = 9;
  localparam int HOLD_CYCLES       = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT    = 4000;  // cycles with no transfer at all
  localparam int SETTLE_CYCLES     = 64;    // settle after the final drain
  localparam int NUM_SETTINGS      = 12;
  localparam int TICKS_PER_SETTING = 152;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Idle percentages of the current phase, set only by the stimulus process
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // Hold-off request: the stimulus bumps hold_token, the receiver serves it
  int unsigned hold_token = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned settings_run = 0;

  duty_polarity_tracker tracker = new();

  hbridge_duty_polarity_update DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Monitor at the rising edge. The output side is checked before the input
  // side is noted; a tick cannot produce its own update in the same cycle
  // anyway, given the divider latency. The watchdog counts cycles in which
  // neither channel completes a transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) tracker.check_update(out_data);
      if (in_valid && !in_stall) tracker.note_tick(in_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d updates outstanding",
                 quiet_cycles, tracker.pending_updates.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stall at the falling edge, or a long hold-off when one
  // is requested. The hold-off is counted here, so the sender keeps offering
  // ticks and the block fills up and stalls its input.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_token != hold_taken) begin
      hold_taken = hold_token;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic in_t mk_tick(bit fault, bit act, logic [SP_W-1:0] sp);
    in_t t;
    t.fault_in = fault;
    t.active   = act;
    t.setpoint = sp;
    return t;
  endfunction

  // Mostly driven ticks, some idle periods and occasional faults; setpoints
  // spread over the whole range with extra weight near full scale and ends.
  function automatic in_t random_tick();
    in_t t;
    t.fault_in = ($urandom_range(99) < 8);
    t.active   = ($urandom_range(99) < 80);
    case ($urandom_range(3))
      0, 1:    t.setpoint = SP_W'($urandom_range(4095));
      2:       t.setpoint = SP_W'($urandom_range(2550, 2450));
      default: t.setpoint = $urandom_range(1) ? '1 : SP_W'($urandom_range(15));
    endcase
    return t;
  endfunction

  // One tick transfer: optional idle cycles, then hold valid until accepted.
  // Valid stays high straight into the next tick when no idle is drawn.
  task automatic send_tick(in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Sender pauses until every predicted update has been taken. Each tick
  // yields exactly one update, so the block is idle once the queue is empty.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_updates.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  // Full register set, written back to back while the block is idle. Raw
  // 14-bit data is passed so upper bits beyond a register's width get
  // exercised and must be dropped.
  task automatic apply_setting(logic [CFG_W-1:0] mode, logic [CFG_W-1:0] freq,
                               logic [CFG_W-1:0] per, logic [CFG_W-1:0] cap);
    wait_drained();
    write_reg(REG_AC_MODE, mode);
    write_reg(REG_AC_FREQ, freq);
    write_reg(REG_PWM_PER, per);
    write_reg(REG_MAX_DUTY, cap);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  initial begin
    int unsigned s;
    int unsigned k;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed ticks, reset registers: direct polarity
    send_idle_pct = 26;
    recv_idle_pct = 68;
    send_tick(mk_tick(1'b0, 1'b1, SP_W'(0)));
    send_tick(mk_tick(1'b0, 1'b1, SP_W'(4095)));    // clamps to max duty
    send_tick(mk_tick(1'b0, 1'b1, SP_FULL_SCALE));  // full period, clamped
    send_tick(mk_tick(1'b0, 1'b1, SP_W'(1000)));
    send_tick(mk_tick(1'b0, 1'b0, SP_W'(2000)));    // output off
    send_tick(mk_tick(1'b1, 1'b1, SP_W'(3000)));    // fault beats the request
    send_tick(mk_tick(1'b1, 1'b0, SP_W'(4095)));
    send_tick(mk_tick(1'b0, 1'b1, SP_W'(12'hAAA)));
    send_tick(mk_tick(1'b0, 1'b1, SP_W'(12'h555)));

    // AC at the shortest usual half period: side flips on the eighth tick
    apply_setting(CFG_W'(1), CFG_W'(1000), CFG_W'(16383), CFG_W'(16383));
    for (k = 0; k < 10; k++) send_tick(mk_tick(1'b0, 1'b1, SP_W'(k * 409)));
    send_tick(mk_tick(1'b0, 1'b0, SP_W'(100)));     // off, polarity kept
    send_tick(mk_tick(1'b1, 1'b1, SP_W'(4095)));

    // Frequency with only upper bits set reads as zero; zero period and cap
    apply_setting(CFG_W'(1), CFG_W'(14'h3C00), CFG_W'(0), CFG_W'(0));
    send_tick(mk_tick(1'b0, 1'b1, SP_W'(4095)));
    send_tick(mk_tick(1'b0, 1'b0, SP_W'(4095)));

    // Random part: three idling phases of four register settings each
    for (s = 0; s < NUM_SETTINGS; s++) begin
      if (s < 4) begin
        send_idle_pct = 26;
        recv_idle_pct = 68;
      end else if (s < 8) begin
        send_idle_pct = 68;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (s)
        0:  apply_setting(CFG_W'(1), CFG_W'(100), CFG_W'(4500), CFG_W'(4185));
        1:  apply_setting(CFG_W'(1), CFG_W'(1000), CFG_W'(16383), CFG_W'(16383));
        2:  apply_setting(CFG_W'(0), CFG_W'(1), CFG_W'(1), CFG_W'(0));
        // long half period: the counter climbs well past a short threshold
        3:  apply_setting(CFG_W'(1), CFG_W'(5), CFG_W'(2500), CFG_W'(16383));
        // shortest threshold with the count left above it
        4:  apply_setting(CFG_W'(1), CFG_W'(1023), CFG_W'(4500), CFG_W'(4185));
        5:  apply_setting(CFG_W'(1), CFG_W'(14'h3C00), CFG_W'(14'h3FFF),
                          CFG_W'(14'h2000));
        6:  apply_setting(CFG_W'(0), CFG_W'($urandom_range(16383)),
                          CFG_W'($urandom_range(16383)), CFG_W'($urandom_range(16383)));
        7:  apply_setting(CFG_W'(1), CFG_W'(0), CFG_W'(0),
                          CFG_W'($urandom_range(16383)));
        8:  apply_setting(CFG_W'(14'h3FFF), CFG_W'(14'h3C07),
                          CFG_W'($urandom_range(16383)), CFG_W'($urandom_range(16383)));
        9:  apply_setting(CFG_W'(1), CFG_W'(1), CFG_W'($urandom_range(16383)),
                          CFG_W'(16383));
        10: apply_setting(CFG_W'(14'h2AAA), CFG_W'($urandom_range(16383)),
                          CFG_W'($urandom_range(16383)), CFG_W'($urandom_range(16383)));
        default: apply_setting(CFG_W'(1), CFG_W'($urandom_range(1000, 1)),
                               CFG_W'($urandom_range(16383, 1)),
                               CFG_W'($urandom_range(16383)));
      endcase
      // receiver holds off while the sender streams with no gaps
      if (s == 9) hold_token++;
      for (k = 0; k < TICKS_PER_SETTING; k++) send_tick(random_tick());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d ticks over %0d register settings, %0d updates checked, %0d bad",
             tracker.ticks, settings_run, tracker.updates, tracker.mismatches);
    $display("fault trips %0d, polarity flips %0d, duty clamps %0d",
             tracker.trips, tracker.flips, tracker.clamps);
    if (tracker.mismatches == 0 && tracker.pending_updates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
